// ===== hw/rtl/ogru_pkg.sv =====
// shared types, constants and codes of the occupancy grid ray update block
package ogru_pkg;

    localparam int unsigned COORD_W             = 7;
    localparam int unsigned SCORE_W             = 5;
    localparam int unsigned LIMIT_W             = 4;
    localparam int unsigned COUNT_W             = 8;
    localparam int unsigned ERR_W               = COORD_W + 3;
    localparam int unsigned CFG_INDEX_W         = 2;
    localparam int unsigned CFG_DATA_W          = 7;
    localparam int unsigned GRID_SIDE_DEFAULT   = 128;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    // longest possible ray on a 128 x 128 coordinate range
    localparam logic [COUNT_W-1:0] TRACED_MAX = 8'd128;

    localparam logic [COORD_W-1:0] ROBOT_X_RESET     = 7'd50;
    localparam logic [COORD_W-1:0] ROBOT_Y_RESET     = 7'd50;
    localparam logic [LIMIT_W-1:0] SCORE_LIMIT_RESET = 4'd10;

    // func codes of a command
    localparam logic [1:0] FUNC_HIT  = 2'd0;
    localparam logic [1:0] FUNC_RAY  = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROBOT_X     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROBOT_Y     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCORE_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        KIND_HIT,
        KIND_RAY,
        KIND_READ
    } kind_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } cmd_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] cell_score;
        logic [COUNT_W-1:0]        traced_cells;
    } result_t;

    // classified command with line setup, queued between front and back
    typedef struct packed {
        kind_t                   kind;
        logic [COORD_W-1:0]      x0;
        logic [COORD_W-1:0]      y0;
        logic [COORD_W-1:0]      x1;
        logic [COORD_W-1:0]      y1;
        logic [COORD_W-1:0]      dx;
        logic [COORD_W-1:0]      dy;
        logic                    sx;
        logic                    sy;
        logic signed [ERR_W-1:0] err;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef struct packed {
        logic clearing;
        logic walking;
        logic updating;
    } back_status_t;

endpackage

// ===== hw/rtl/ogru_ram.sv =====
// generic single write port, single read port ram with registered read
module ogru_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/ogru_front.sv =====
// front end: classifies a command and sets up its line walk
module ogru_front (
    input  ogru_pkg::cmd_t                 cmd,
    input  logic [ogru_pkg::COORD_W-1:0]   robot_x,
    input  logic [ogru_pkg::COORD_W-1:0]   robot_y,
    output ogru_pkg::job_t                 job
);

    localparam int unsigned PAD_W = ogru_pkg::ERR_W - ogru_pkg::COORD_W;

    ogru_pkg::kind_t              kind;
    logic [ogru_pkg::COORD_W-1:0] x0;
    logic [ogru_pkg::COORD_W-1:0] y0;
    logic [ogru_pkg::COORD_W-1:0] dx;
    logic [ogru_pkg::COORD_W-1:0] dy;

    always_comb
    begin
        case (cmd.func)
            ogru_pkg::FUNC_HIT:  kind = ogru_pkg::KIND_HIT;
            ogru_pkg::FUNC_RAY:  kind = ogru_pkg::KIND_RAY;
            default:             kind = ogru_pkg::KIND_READ;
        endcase
    end

    // single cell commands walk a line of length one
    assign x0 = (kind == ogru_pkg::KIND_RAY) ? robot_x : cmd.end_x;
    assign y0 = (kind == ogru_pkg::KIND_RAY) ? robot_y : cmd.end_y;

    assign dx = (cmd.end_x >= x0) ? (cmd.end_x - x0) : (x0 - cmd.end_x);
    assign dy = (cmd.end_y >= y0) ? (cmd.end_y - y0) : (y0 - cmd.end_y);

    always_comb
    begin
        job.kind = kind;
        job.x0   = x0;
        job.y0   = y0;
        job.x1   = cmd.end_x;
        job.y1   = cmd.end_y;
        job.dx   = dx;
        job.dy   = dy;
        job.sx   = (x0 < cmd.end_x);
        job.sy   = (y0 < cmd.end_y);
        job.err  = $signed({{PAD_W{1'b0}}, dx}) - $signed({{PAD_W{1'b0}}, dy});
    end

endmodule

// ===== hw/rtl/ogru_queue.sv =====
// short job queue between front end and back end
module ogru_queue #(
    parameter int unsigned DEPTH = ogru_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ogru_pkg::job_t          push_data,
    input  logic                    pop,
    output ogru_pkg::job_t          pop_data,
    output ogru_pkg::queue_status_t status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ogru_pkg::job_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));

endmodule

// ===== hw/rtl/ogru_back.sv =====
// back end: clear pass, line walk and per cell read-modify-write of the grid
module ogru_back #(
    parameter int unsigned GRID_SIDE = ogru_pkg::GRID_SIDE_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    input  ogru_pkg::job_t               job,
    output logic                         job_pop,
    input  logic [ogru_pkg::LIMIT_W-1:0] score_limit,
    output logic                         done,
    output ogru_pkg::result_t            result,
    output ogru_pkg::back_status_t       status
);

    localparam int unsigned DEPTH  = GRID_SIDE * GRID_SIDE;
    localparam int unsigned AW     = $clog2(DEPTH);
    localparam int unsigned MULW   = AW + ogru_pkg::COORD_W + 1;
    localparam int unsigned CW     = ogru_pkg::COORD_W;
    localparam int unsigned SW     = ogru_pkg::SCORE_W;
    localparam int unsigned EW     = ogru_pkg::ERR_W;
    localparam int unsigned E2_PAD = EW + 1 - CW;
    localparam int unsigned LIM_PAD = SW + 1 - ogru_pkg::LIMIT_W;

    function automatic logic on_grid(logic [CW-1:0] x, logic [CW-1:0] y);
        return (32'(x) < GRID_SIDE) && (32'(y) < GRID_SIDE);
    endfunction

    function automatic logic [AW-1:0] cell_addr(logic [CW-1:0] x, logic [CW-1:0] y);
        logic [MULW-1:0] full;
        full = MULW'(y) * MULW'(GRID_SIDE) + MULW'(x);
        return full[AW-1:0];
    endfunction

    // clear pass
    logic          clear_active_reg;
    logic [AW-1:0] clear_addr_reg;

    // walk stage
    logic                         walk_active_reg;
    ogru_pkg::kind_t              walk_kind_reg;
    logic [CW-1:0]                cur_x_reg;
    logic [CW-1:0]                cur_y_reg;
    logic [CW-1:0]                end_x_reg;
    logic [CW-1:0]                end_y_reg;
    logic [CW-1:0]                dx_reg;
    logic [CW-1:0]                dy_reg;
    logic                         sx_reg;
    logic                         sy_reg;
    logic signed [EW-1:0]         err_reg;
    logic [ogru_pkg::COUNT_W-1:0] count_reg;

    // update stage
    logic                         upd_valid_reg;
    logic                         upd_last_reg;
    logic                         upd_on_grid_reg;
    logic [AW-1:0]                upd_addr_reg;
    ogru_pkg::kind_t              upd_kind_reg;
    logic [ogru_pkg::COUNT_W-1:0] upd_count_reg;

    logic              done_reg;
    ogru_pkg::result_t result_reg;
    ogru_pkg::result_t result_next;

    logic                 load;
    logic                 at_end;
    logic                 cur_on_grid;
    logic [AW-1:0]        cur_addr;
    logic signed [EW:0]   e2;
    logic signed [EW:0]   dx_s;
    logic signed [EW:0]   dy_s;
    logic                 step_x;
    logic                 step_y;
    logic signed [EW:0]   err_sum;
    logic [CW-1:0]        next_x;
    logic [CW-1:0]        next_y;

    logic [SW-1:0]        rd_data;
    logic signed [SW:0]   old_w;
    logic signed [SW:0]   lim_w;
    logic signed [SW:0]   new_w;
    logic                 upd_write;
    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [SW-1:0]        ram_wr_data;

    assign load        = !clear_active_reg && !walk_active_reg && job_valid;
    assign job_pop     = load;
    assign at_end      = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);
    assign cur_on_grid = on_grid(cur_x_reg, cur_y_reg);
    assign cur_addr    = cell_addr(cur_x_reg, cur_y_reg);

    // one bresenham step per cycle
    assign e2      = {err_reg, 1'b0};
    assign dx_s    = $signed({{E2_PAD{1'b0}}, dx_reg});
    assign dy_s    = $signed({{E2_PAD{1'b0}}, dy_reg});
    assign step_x  = (e2 >= -dy_s);
    assign step_y  = (e2 <= dx_s);
    assign err_sum = {err_reg[EW-1], err_reg} - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
    assign next_x  = step_x ? (sx_reg ? cur_x_reg + 1'b1 : cur_x_reg - 1'b1) : cur_x_reg;
    assign next_y  = step_y ? (sy_reg ? cur_y_reg + 1'b1 : cur_y_reg - 1'b1) : cur_y_reg;

    // saturating update of the cell read in the previous cycle
    assign old_w = upd_on_grid_reg ? {rd_data[SW-1], rd_data} : '0;
    assign lim_w = $signed({{LIM_PAD{1'b0}}, score_limit});

    always_comb
    begin
        new_w = old_w;
        case (upd_kind_reg)
            ogru_pkg::KIND_HIT:
            begin
                if (old_w < lim_w)
                begin
                    new_w = old_w + 1'b1;
                end
            end
            ogru_pkg::KIND_RAY:
            begin
                if (old_w > -lim_w)
                begin
                    new_w = old_w - 1'b1;
                end
            end
            default:
            begin
                new_w = old_w;
            end
        endcase
    end

    assign upd_write = upd_valid_reg && upd_on_grid_reg && (upd_kind_reg != ogru_pkg::KIND_READ);

    always_comb
    begin
        result_next.cell_score   = upd_on_grid_reg ? new_w[SW-1:0] : '0;
        result_next.traced_cells = (upd_kind_reg == ogru_pkg::KIND_RAY) ? upd_count_reg : '0;
    end

    assign ram_wr_en   = clear_active_reg || upd_write;
    assign ram_wr_addr = clear_active_reg ? clear_addr_reg : upd_addr_reg;
    assign ram_wr_data = clear_active_reg ? '0 : new_w[SW-1:0];

    ogru_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (walk_active_reg && cur_on_grid),
        .rd_addr (cur_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            walk_active_reg  <= 1'b0;
            upd_valid_reg    <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (clear_active_reg)
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
                if (clear_addr_reg == AW'(DEPTH - 1))
                begin
                    clear_active_reg <= 1'b0;
                end
            end
            if (load)
            begin
                walk_active_reg <= 1'b1;
            end
            else if (walk_active_reg && at_end)
            begin
                walk_active_reg <= 1'b0;
            end
            upd_valid_reg <= walk_active_reg;
            done_reg      <= upd_valid_reg && upd_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            walk_kind_reg <= job.kind;
            cur_x_reg     <= job.x0;
            cur_y_reg     <= job.y0;
            end_x_reg     <= job.x1;
            end_y_reg     <= job.y1;
            dx_reg        <= job.dx;
            dy_reg        <= job.dy;
            sx_reg        <= job.sx;
            sy_reg        <= job.sy;
            err_reg       <= job.err;
            count_reg     <= ogru_pkg::COUNT_W'(1);
        end
        else if (walk_active_reg && !at_end)
        begin
            cur_x_reg <= next_x;
            cur_y_reg <= next_y;
            err_reg   <= err_sum[EW-1:0];
            count_reg <= count_reg + 1'b1;
        end
        upd_last_reg    <= at_end;
        upd_on_grid_reg <= cur_on_grid;
        upd_addr_reg    <= cur_addr;
        upd_kind_reg    <= walk_kind_reg;
        upd_count_reg   <= count_reg;
        result_reg      <= result_next;
    end

    assign done            = done_reg;
    assign result          = result_reg;
    assign status.clearing = clear_active_reg;
    assign status.walking  = walk_active_reg;
    assign status.updating = upd_valid_reg;

endmodule

// ===== hw/rtl/occupancy_grid_ray_update.sv =====
// top level of the occupancy grid ray update block
//
// channel   direction  handshake                 payload
// -------   ---------  ------------------------  ------------------------------
// command   in         start & !busy             cmd (func, end_x, end_y)
// result    out        done, one cycle, no stall result (cell_score, traced_cells)
// config    in         cfg_we                    cfg_index, cfg_data
//
// a ray is loaded from the queue and then walks its cells from the robot
// position to the end point; hit and read walk a single cell. the grid ram
// does one read-modify-write per cell per cycle. the result strobe is
// registered from the update stage of the last cell. after reset a clear pass
// writes zero to all GRID_SIDE*GRID_SIDE cells (16384 at the default) with
// busy high. the result side cannot stall; busy rises only for the clear pass
// or a full job queue.
module occupancy_grid_ray_update #(
    parameter int unsigned GRID_SIDE   = ogru_pkg::GRID_SIDE_DEFAULT,
    parameter int unsigned QUEUE_DEPTH = ogru_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  ogru_pkg::cmd_t                   cmd,
    output logic                             done,
    output ogru_pkg::result_t                result,
    input  logic                             cfg_we,
    input  logic [ogru_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ogru_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [ogru_pkg::COORD_W-1:0] robot_x_reg;
    logic [ogru_pkg::COORD_W-1:0] robot_y_reg;
    logic [ogru_pkg::LIMIT_W-1:0] score_limit_reg;

    logic                    accept;
    ogru_pkg::job_t          front_job;
    ogru_pkg::job_t          queue_job;
    logic                    queue_pop;
    ogru_pkg::queue_status_t queue_status;
    ogru_pkg::back_status_t  back_status;

    // writes beyond the register list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            robot_x_reg     <= ogru_pkg::ROBOT_X_RESET;
            robot_y_reg     <= ogru_pkg::ROBOT_Y_RESET;
            score_limit_reg <= ogru_pkg::SCORE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ogru_pkg::CFG_ROBOT_X:     robot_x_reg     <= cfg_data;
                ogru_pkg::CFG_ROBOT_Y:     robot_y_reg     <= cfg_data;
                ogru_pkg::CFG_SCORE_LIMIT: score_limit_reg <= cfg_data[ogru_pkg::LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // a transaction is taken whenever the queue has room and the grid is cleared
    assign busy   = back_status.clearing || queue_status.full;
    assign accept = start && !busy;

    ogru_front u_front (
        .cmd     (cmd),
        .robot_x (robot_x_reg),
        .robot_y (robot_y_reg),
        .job     (front_job)
    );

    ogru_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_job),
        .pop       (queue_pop),
        .pop_data  (queue_job),
        .status    (queue_status)
    );

    // back end pops the next job as soon as its walk stage is free
    ogru_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (!queue_status.empty),
        .job         (queue_job),
        .job_pop     (queue_pop),
        .score_limit (score_limit_reg),
        .done        (done),
        .result      (result),
        .status      (back_status)
    );

`ifndef SYNTH
    // no result can appear while the grid is still being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.clearing |-> !done)
        else $error("result strobe during clear pass");

    // an accepted transaction is either queued or already walking
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (!queue_status.empty || back_status.walking))
        else $error("accepted transaction lost between front and back");

    // a walk never starts while the clear pass still owns the ram
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.walking |-> !back_status.clearing)
        else $error("walk overlaps clear pass");

    // a result strobe always follows an update cycle of the back end
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(back_status.updating))
        else $error("result strobe without an update cycle");

    // a ray never visits more cells than the coordinate range holds
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.traced_cells <= ogru_pkg::TRACED_MAX))
        else $error("traced cell count out of range");
`endif

endmodule
